/* hdl/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and classification helpers for the
// scene text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned LineCountWidth = 24;
  localparam int unsigned LineNumW       = 24;
  localparam int unsigned EvqDepth       = 4;
  localparam int unsigned EvqPtrW        = $clog2(EvqDepth);
  localparam int unsigned EvqCntW        = $clog2(EvqDepth + 1);

  localparam logic [7:0] CharHash      = 8'h23;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharCr        = 8'h0d;
  localparam logic [7:0] CharLf        = 8'h0a;
  localparam logic [7:0] CharBar       = 8'h7c;
  localparam logic [7:0] CharComma     = 8'h2c;
  localparam logic [7:0] CharUnder     = 8'h5f;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharSlash     = 8'h2f;
  localparam logic [7:0] CharColon     = 8'h3a;
  localparam logic [7:0] CharDot       = 8'h2e;
  localparam logic [7:0] CharMinus     = 8'h2d;
  localparam logic [7:0] CharPlus      = 8'h2b;
  localparam logic [7:0] CharLowX      = 8'h78;
  localparam logic [7:0] CharUpX       = 8'h58;
  localparam logic [7:0] CharLowE      = 8'h65;
  localparam logic [7:0] CharUpE       = 8'h45;
  localparam logic [7:0] CharLbrace    = 8'h7b;
  localparam logic [7:0] CharRbrace    = 8'h7d;
  localparam logic [7:0] CharLparen    = 8'h28;
  localparam logic [7:0] CharRparen    = 8'h29;
  localparam logic [7:0] CharLbrack    = 8'h5b;
  localparam logic [7:0] CharRbrack    = 8'h5d;

  typedef enum logic [3:0] {
    KindEnd     = 4'd0,
    KindKeyword = 4'd1,
    KindNumber  = 4'd2,
    KindLbrace  = 4'd3,
    KindRbrace  = 4'd4,
    KindLparen  = 4'd5,
    KindRparen  = 4'd6,
    KindBar     = 4'd7,
    KindComma   = 4'd8,
    KindLbrack  = 4'd9,
    KindRbrack  = 4'd10
  } kind_e;

  typedef enum logic [4:0] {
    ModeIdle    = 5'b00001,
    ModeComment = 5'b00010,
    ModeString  = 5'b00100,
    ModeKeyword = 5'b01000,
    ModeNumber  = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          data;
    logic                has;
    logic                starts;
    logic                ends;
    logic                bad;
    logic [LineNumW-1:0] line;
    logic                last;
  } evt_t;

  function automatic evt_t mk_ev(kind_e kind, logic [7:0] data, logic has,
                                 logic starts, logic ends, logic bad,
                                 logic [LineNumW-1:0] line);
    evt_t e;
    e.kind   = kind;
    e.data   = data;
    e.has    = has;
    e.starts = starts;
    e.ends   = ends;
    e.bad    = bad;
    e.line   = line;
    e.last   = 1'b0;
    return e;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic kw_start(logic [7:0] c);
    return is_alpha(c) || c == CharUnder || c == CharSlash || c == CharBackslash ||
           c == CharColon;
  endfunction

  function automatic logic kw_cont(logic [7:0] c);
    return kw_start(c) || is_digit(c) || c == CharDot || c == CharMinus;
  endfunction

  function automatic logic num_start(logic [7:0] c);
    return is_digit(c) || c == CharDot || c == CharPlus || c == CharMinus;
  endfunction

  function automatic logic num_cont(logic [7:0] c, logic [1:0] pos);
    return is_xdigit(c) || (pos == 2'd1 && (c == CharLowX || c == CharUpX)) ||
           c == CharDot || c == CharPlus || c == CharMinus ||
           c == CharLowE || c == CharUpE;
  endfunction

  function automatic kind_e punct_kind(logic [7:0] c);
    kind_e k;
    case (c)
      CharLbrace: k = KindLbrace;
      CharRbrace: k = KindRbrace;
      CharLparen: k = KindLparen;
      CharRparen: k = KindRparen;
      CharBar:    k = KindBar;
      CharComma:  k = KindComma;
      CharLbrack: k = KindLbrack;
      CharRbrack: k = KindRbrack;
      default:    k = KindEnd;
    endcase
    return k;
  endfunction

endpackage

/* hdl/scene_text_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_text_tokenizer
// Streaming lexical scanner: one character per transaction in, token events out.
// ----------------------------------------------------------------------------
// Output: the decode is combinational and its events are registered in the event queue.
// Throughput: one character per cycle while each gives at most one event and the output
// is not stalled; a character that closes a token and opens another gives two events,
// which leave the single output port one at a time, so the queue sets the sustained rate.
// Reset: asynchronous, active low; clears the scan mode, line count and event queue.
// ----------------------------------------------------------------------------
module scene_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [8] has_byte, [9] starts_token, [10] ends_token,
  // [11] bad_char, [35:12] line_number, [39:36] zero
  output logic [39:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // [3:0] token_kind
  output logic        m_axis_tlast   // last_event
);
  import stt_pkg::*;

  logic       accept;
  logic       room;
  logic [1:0] ev_cnt;
  logic [1:0] push_cnt;
  evt_t       ev0, ev1, head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;
  assign push_cnt      = accept ? ev_cnt : 2'd0;

  stt_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (s_axis_tdata),
    .eoi_i     (s_axis_tlast),
    .ev0_o     (ev0),
    .ev1_o     (ev1),
    .ev_cnt_o  (ev_cnt)
  );

  stt_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .ev0_i      (ev0),
    .ev1_i      (ev1),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = {4'd0, head.line, head.bad, head.ends, head.starts, head.has,
                         head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

/* hdl/stt_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and the single-pass decode of one character into up to two
// token events.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          eoi_i,
  output stt_pkg::evt_t ev0_o,
  output stt_pkg::evt_t ev1_o,
  output logic [1:0]    ev_cnt_o
);
  import stt_pkg::*;

  mode_e                     mode_q, mode_d;
  logic [1:0]                pos_q, pos_d;
  logic                      cr_q, cr_d;
  logic [LineCountWidth-1:0] line_q, line_d;

  logic                      is_cr, is_lf, nl, drop_lf;
  logic [7:0]                c;
  logic [LineCountWidth-1:0] line_inc;
  logic [LineNumW-1:0]       lnum_byte, lnum_eoi;

  evt_t                      idle_ev;
  logic                      idle_fire;
  mode_e                     idle_mode;
  logic [1:0]                idle_pos;
  kind_e                     pk;

  assign is_cr     = (in_byte_i == CharCr);
  assign is_lf     = (in_byte_i == CharLf);
  assign nl        = is_cr || is_lf;
  assign drop_lf   = cr_q && is_lf;
  assign c         = nl ? CharLf : in_byte_i;
  assign line_inc  = (nl && line_q != '1) ? line_q + 1'b1 : line_q;
  assign lnum_byte = LineNumW'(line_inc);
  assign lnum_eoi  = LineNumW'(line_q);
  assign pk        = punct_kind(c);

  // What a character does when no token is open.
  always_comb begin
    idle_fire = 1'b1;
    idle_mode = ModeIdle;
    idle_pos  = 2'd0;
    idle_ev   = mk_ev(KindEnd, c, 1'b0, 1'b0, 1'b0, 1'b1, lnum_byte);
    if (is_space(c)) begin
      idle_fire = 1'b0;
    end else if (c == CharHash) begin
      idle_fire = 1'b0;
      idle_mode = ModeComment;
    end else if (c == CharQuote) begin
      idle_mode = ModeString;
      idle_ev   = mk_ev(KindKeyword, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, lnum_byte);
    end else if (pk != KindEnd) begin
      idle_ev   = mk_ev(pk, c, 1'b1, 1'b1, 1'b1, 1'b0, lnum_byte);
    end else if (kw_start(c)) begin
      idle_mode = ModeKeyword;
      idle_ev   = mk_ev(KindKeyword, c, 1'b1, 1'b1, 1'b0, 1'b0, lnum_byte);
    end else if (num_start(c)) begin
      idle_mode = ModeNumber;
      idle_pos  = 2'd1;
      idle_ev   = mk_ev(KindNumber, c, 1'b1, 1'b1, 1'b0, 1'b0, lnum_byte);
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    cr_d     = cr_q;
    line_d   = line_q;
    ev0_o    = '0;
    ev1_o    = '0;
    ev_cnt_o = 2'd0;
    if (eoi_i) begin
      mode_d = ModeIdle;
      pos_d  = 2'd0;
      cr_d   = 1'b0;
      if (mode_q == ModeString || mode_q == ModeKeyword || mode_q == ModeNumber) begin
        ev0_o    = mk_ev((mode_q == ModeNumber) ? KindNumber : KindKeyword, 8'd0, 1'b0,
                         1'b0, 1'b1, 1'b0, lnum_eoi);
        ev1_o    = mk_ev(KindEnd, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, lnum_eoi);
        ev_cnt_o = 2'd2;
      end else begin
        ev0_o    = mk_ev(KindEnd, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, lnum_eoi);
        ev_cnt_o = 2'd1;
      end
    end else if (drop_lf) begin
      // Second half of a CR-LF pair: already counted.
      cr_d = 1'b0;
    end else begin
      cr_d   = is_cr;
      line_d = line_inc;
      case (mode_q)
        ModeComment: begin
          if (nl) begin
            mode_d = ModeIdle;
          end
        end
        ModeString: begin
          ev_cnt_o = 2'd1;
          if (c == CharQuote) begin
            mode_d = ModeIdle;
            ev0_o  = mk_ev(KindKeyword, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, lnum_byte);
          end else begin
            ev0_o  = mk_ev(KindKeyword, c, 1'b1, 1'b0, 1'b0, 1'b0, lnum_byte);
          end
        end
        ModeKeyword: begin
          if (kw_cont(c)) begin
            ev0_o    = mk_ev(KindKeyword, c, 1'b1, 1'b0, 1'b0, 1'b0, lnum_byte);
            ev_cnt_o = 2'd1;
          end else begin
            // The terminating character is scanned again as if between tokens.
            ev0_o    = mk_ev(KindKeyword, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, lnum_byte);
            ev1_o    = idle_ev;
            ev_cnt_o = idle_fire ? 2'd2 : 2'd1;
            mode_d   = idle_mode;
            pos_d    = idle_pos;
          end
        end
        ModeNumber: begin
          if (num_cont(c, pos_q)) begin
            ev0_o    = mk_ev(KindNumber, c, 1'b1, 1'b0, 1'b0, 1'b0, lnum_byte);
            ev_cnt_o = 2'd1;
            if (pos_q < 2'd2) begin
              pos_d = pos_q + 2'd1;
            end
          end else begin
            ev0_o    = mk_ev(KindNumber, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, lnum_byte);
            ev1_o    = idle_ev;
            ev_cnt_o = idle_fire ? 2'd2 : 2'd1;
            mode_d   = idle_mode;
            pos_d    = idle_pos;
          end
        end
        default: begin
          ev0_o    = idle_ev;
          ev_cnt_o = idle_fire ? 2'd1 : 2'd0;
          mode_d   = idle_mode;
          pos_d    = idle_pos;
        end
      endcase
    end
    if (ev_cnt_o == 2'd2) begin
      ev1_o.last = 1'b1;
    end else begin
      ev0_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pos_q  <= 2'd0;
      cr_q   <= 1'b0;
      line_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      cr_q   <= cr_d;
      line_q <= line_d;
    end
  end

endmodule

/* hdl/stt_evq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_evq
// Small result queue that takes up to two token events per cycle and hands
// out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module stt_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  stt_pkg::evt_t ev0_i,
  input  stt_pkg::evt_t ev1_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output stt_pkg::evt_t head_o
);
  import stt_pkg::*;

  evt_t               mem_q [EvqDepth];
  logic [EvqPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [EvqCntW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign valid_o   = (cnt_q != '0);
  // Room for the worst case of two events from one transaction.
  assign room_o    = (cnt_q <= EvqCntW'(EvqDepth - 2));
  assign pop       = valid_o && ready_i;
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + EvqPtrW'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + EvqCntW'(push_cnt_i) - EvqCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= ev0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= ev1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* verif/scene_text_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_text_tokenizer_tb
// Self-checking bench for the streaming tokenizer. A driver feeds characters
// and end marks from a queue, a scanner model in the bench predicts the token
// events each accepted character causes, and a monitor compares every event
// leaving the block field by field. Both stream sides idle and stall at random
// in several phases, and one long output stall fills the block up.
// ----------------------------------------------------------------------------
module scene_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int unsigned ClkHalf     = 2;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomItems = 650;

  typedef enum logic [2:0] {
    ScanIdle,
    ScanComment,
    ScanString,
    ScanWord,
    ScanNumber
  } scan_e;

  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
  } char_item_t;

  typedef struct {
    kind_e                     kind;
    logic [7:0]                data;
    logic                      has;
    logic                      starts;
    logic                      ends;
    logic                      bad;
    logic [LineCountWidth-1:0] line;
    logic                      last;
  } token_event_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  char_item_t   pending_chars[$];
  token_event_t token_events_q[$];

  // Scanner state of the prediction.
  scan_e                     scan_mode  = ScanIdle;
  logic                      after_cr   = 1'b0;
  logic [1:0]                num_pos    = 2'd0;
  logic [LineCountWidth-1:0] line_cnt   = '0;

  int unsigned errors       = 0;
  int unsigned accepted_cnt = 0;
  int unsigned total_items  = 1;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_cnt     = 0;
  logic        hold_done    = 1'b0;
  logic        rx_hold      = 1'b0;

  scene_text_tokenizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever begin
      #ClkHalf clk_i = ~clk_i;
    end
  end

  // ---------------------------------------------------------------- classes
  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic word_first(logic [7:0] c);
    return is_letter(c) || c == CharUnder || c == CharSlash || c == CharBackslash ||
           c == CharColon;
  endfunction

  function automatic logic word_more(logic [7:0] c);
    return word_first(c) || is_num(c) || c == CharDot || c == CharMinus;
  endfunction

  function automatic logic num_first(logic [7:0] c);
    return is_num(c) || c == CharDot || c == CharPlus || c == CharMinus;
  endfunction

  // The hex prefix letter is only part of a number as its second character.
  function automatic logic num_more(logic [7:0] c, logic [1:0] pos);
    return is_hex(c) || (pos == 2'd1 && (c == CharLowX || c == CharUpX)) ||
           c == CharDot || c == CharPlus || c == CharMinus || c == CharLowE ||
           c == CharUpE;
  endfunction

  function automatic kind_e punct_of(logic [7:0] c);
    case (c)
      CharLbrace: return KindLbrace;
      CharRbrace: return KindRbrace;
      CharLparen: return KindLparen;
      CharRparen: return KindRparen;
      CharBar:    return KindBar;
      CharComma:  return KindComma;
      CharLbrack: return KindLbrack;
      CharRbrack: return KindRbrack;
      default:    return KindEnd;
    endcase
  endfunction

  // ------------------------------------------------------------- prediction
  task automatic emit(kind_e kind, logic [7:0] data, logic has, logic starts,
                      logic ends, logic bad);
    token_event_t ev;
    ev.kind   = kind;
    ev.data   = data;
    ev.has    = has;
    ev.starts = starts;
    ev.ends   = ends;
    ev.bad    = bad;
    ev.line   = line_cnt;
    ev.last   = 1'b0;
    token_events_q.push_back(ev);
  endtask

  task automatic open_from_idle(logic [7:0] c);
    kind_e p;
    p = punct_of(c);
    if (is_blank(c)) begin
    end else if (c == CharHash) begin
      scan_mode = ScanComment;
    end else if (c == CharQuote) begin
      scan_mode = ScanString;
      emit(KindKeyword, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    end else if (p != KindEnd) begin
      emit(p, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (word_first(c)) begin
      scan_mode = ScanWord;
      emit(KindKeyword, c, 1'b1, 1'b1, 1'b0, 1'b0);
    end else if (num_first(c)) begin
      scan_mode = ScanNumber;
      num_pos   = 2'd1;
      emit(KindNumber, c, 1'b1, 1'b1, 1'b0, 1'b0);
    end else begin
      // Unknown byte: carried for reference, but not part of any token.
      emit(KindEnd, c, 1'b0, 1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic predict_tokens(logic [7:0] in_ch, logic eoi);
    int          prior_cnt;
    logic [7:0]  c;
    prior_cnt = token_events_q.size();
    c         = in_ch;
    if (eoi) begin
      if (scan_mode == ScanString || scan_mode == ScanWord || scan_mode == ScanNumber) begin
        emit(scan_mode == ScanNumber ? KindNumber : KindKeyword, 8'h00, 1'b0, 1'b0,
             1'b1, 1'b0);
      end
      scan_mode = ScanIdle;
      num_pos   = 2'd0;
      after_cr  = 1'b0;
      emit(KindEnd, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    end else if (after_cr && c == CharLf) begin
      // Second half of a CR-LF pair.
      after_cr = 1'b0;
    end else begin
      after_cr = (c == CharCr);
      if (c == CharCr || c == CharLf) begin
        c = CharLf;
        if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      end
      case (scan_mode)
        ScanComment: begin
          if (c == CharLf) scan_mode = ScanIdle;
        end
        ScanString: begin
          if (c == CharQuote) begin
            scan_mode = ScanIdle;
            emit(KindKeyword, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          end else begin
            emit(KindKeyword, c, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
        ScanWord: begin
          if (word_more(c)) begin
            emit(KindKeyword, c, 1'b1, 1'b0, 1'b0, 1'b0);
          end else begin
            emit(KindKeyword, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
            scan_mode = ScanIdle;
            open_from_idle(c);
          end
        end
        ScanNumber: begin
          if (num_more(c, num_pos)) begin
            emit(KindNumber, c, 1'b1, 1'b0, 1'b0, 1'b0);
            if (num_pos < 2'd2) num_pos = num_pos + 2'd1;
          end else begin
            emit(KindNumber, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
            scan_mode = ScanIdle;
            num_pos   = 2'd0;
            open_from_idle(c);
          end
        end
        default: begin
          scan_mode = ScanIdle;
          open_from_idle(c);
        end
      endcase
    end
    if (token_events_q.size() > prior_cnt) begin
      token_events_q[token_events_q.size() - 1].last = 1'b1;
    end
  endtask

  // --------------------------------------------------------------- stimulus
  task automatic add_char(logic [7:0] c);
    char_item_t it;
    it.eoi = 1'b0;
    it.ch  = c;
    pending_chars.push_back(it);
  endtask

  // The byte lane is don't-care with an end mark, so it carries noise.
  task automatic add_eoi();
    char_item_t it;
    it.eoi = 1'b1;
    it.ch  = 8'($urandom_range(0, 255));
    pending_chars.push_back(it);
  endtask

  task automatic add_newline();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    if (pick != 1) add_char(CharCr);
    if (pick != 0) add_char(CharLf);
  endtask

  // One lexically plausible fragment with random content, some noise, or an end mark.
  task automatic add_fragment();
    string       word_set;
    string       num_set;
    string       num_head;
    string       punct_set;
    logic [7:0]  blank_set[4];
    logic [7:0]  c;
    int unsigned pick;
    int unsigned n;
    word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_/\\:0123456789.-";
    num_set   = "0123456789abcdefABCDEF.+-eExX";
    num_head  = "0123456789.+-";
    punct_set = "{}()|,[]";
    blank_set = '{8'h20, 8'h09, 8'h0b, 8'h0c};
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_char(word_set[$urandom_range(0, 55)]);
      n = $urandom_range(0, 5);
      repeat (n) add_char(word_set[$urandom_range(0, word_set.len() - 1)]);
    end else if (pick < 40) begin
      add_char(num_head[$urandom_range(0, num_head.len() - 1)]);
      if ($urandom_range(0, 2) == 0) add_char($urandom_range(0, 1) ? CharLowX : CharUpX);
      n = $urandom_range(0, 4);
      repeat (n) add_char(num_set[$urandom_range(0, num_set.len() - 1)]);
    end else if (pick < 52) begin
      add_char(CharQuote);
      n = $urandom_range(0, 5);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if (c == CharQuote) c = c ^ 8'h01;
        add_char(c);
      end
      if ($urandom_range(0, 4) != 0) add_char(CharQuote);
    end else if (pick < 66) begin
      add_char(punct_set[$urandom_range(0, 7)]);
    end else if (pick < 78) begin
      n = $urandom_range(1, 3);
      repeat (n) add_char(blank_set[$urandom_range(0, 3)]);
    end else if (pick < 84) begin
      add_char(CharHash);
      n = $urandom_range(0, 5);
      repeat (n) add_char(8'($urandom_range(0, 255)));
      add_newline();
    end else if (pick < 92) begin
      add_newline();
    end else if (pick < 98) begin
      add_char(8'($urandom_range(0, 255)));
    end else begin
      add_eoi();
    end
  endtask

  task automatic build_stimulus();
    int unsigned first_random;
    // Every punctuation token.
    add_char(CharLbrace);
    add_char(CharRbrace);
    add_char(CharLparen);
    add_char(CharRparen);
    add_char(CharBar);
    add_char(CharComma);
    add_char(CharLbrack);
    add_char(CharRbrack);
    // Hex prefix in second place, then an X in third place closes the number
    // and opens a keyword; a quote then closes the keyword and opens a string.
    add_char("0");
    add_char(CharLowX);
    add_char(CharUpX);
    add_char(CharQuote);
    add_char(8'hff);
    add_char(CharCr);
    add_char(CharLf);
    add_char(CharQuote);
    // Comment running to end of line, then an unknown byte.
    add_char(CharHash);
    add_char(8'h00);
    add_char(CharLf);
    add_char(8'h01);
    // Repeated end marks, and an end mark inside a number.
    add_eoi();
    add_eoi();
    add_char(CharMinus);
    add_eoi();
    // An end mark after CR forgets the CR, so the LF counts as a new line.
    add_char(CharCr);
    add_eoi();
    add_char(CharLf);
    // End inside a keyword and inside a comment.
    add_char(CharColon);
    add_eoi();
    add_char(CharHash);
    add_eoi();
    first_random = pending_chars.size();
    while (pending_chars.size() < first_random + RandomItems) add_fragment();
    add_eoi();
  endtask

  // ----------------------------------------------------------------- idling
  function automatic int unsigned phase_now();
    return (accepted_cnt * 5) / total_items;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (phase_now())
      1:       return 55;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (phase_now())
      2:       return 55;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  // One long output stall early in the run, while the sender keeps offering.
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done) begin
      if (!rx_hold && accepted_cnt >= total_items / 10) begin
        rx_hold  <= 1'b1;
        hold_cnt <= 0;
      end else if (rx_hold) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HoldCycles) begin
          rx_hold   <= 1'b0;
          hold_done <= 1'b1;
        end
      end
    end
  end

  // ----------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    char_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tokens(s_axis_tdata, s_axis_tlast);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.ch;
          s_axis_tlast  <= nxt.eoi;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    token_event_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_events_q.size() == 0) begin
          $error("token event with none outstanding: kind %0d tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = token_events_q.pop_front();
          check_field("token_kind", int'(want.kind), m_axis_tuser);
          check_field("data_byte", want.data, m_axis_tdata[7:0]);
          check_field("has_byte", want.has, m_axis_tdata[8]);
          check_field("starts_token", want.starts, m_axis_tdata[9]);
          check_field("ends_token", want.ends, m_axis_tdata[10]);
          check_field("bad_char", want.bad, m_axis_tdata[11]);
          check_field("line_number", want.line, m_axis_tdata[35:12]);
          check_field("tdata_pad", 0, m_axis_tdata[39:36]);
          check_field("last_event", want.last, m_axis_tlast);
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // --------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- control
  initial begin
    build_stimulus();
    total_items = pending_chars.size();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (token_events_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && token_events_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/stt_pkg.sv
hdl/stt_scan.sv
hdl/stt_evq.sv
hdl/scene_text_tokenizer.sv
verif/scene_text_tokenizer_tb.sv
